FILE: design/akbe_pkg.sv
// Shared types and constants for the alpha-keyed blit with exposure.
// Depends on nothing; every other file of the block but the two channel interfaces imports it.
package akbe_pkg;

	// Default screen geometry in pixels.
	localparam int ScreenWidthDefault  = 1024;
	localparam int ScreenHeightDefault = 768;

	// Largest image side that the counters cover.
	localparam int MaxSide = 1024;

	// Configuration port address width: seven 32-bit registers at 4*i.
	localparam int CfgAddrW = 5;

	// Register indexes on the configuration port.
	typedef enum logic [2:0] {
		REG_DEST_X          = 3'd0,
		REG_DEST_Y          = 3'd1,
		REG_IMAGE_WIDTH     = 3'd2,
		REG_IMAGE_HEIGHT    = 3'd3,
		REG_EXPOSURE_ENABLE = 3'd4,
		REG_EXPOSURE_VALUE  = 3'd5,
		REG_ALPHA_THRESHOLD = 3'd6
	} akbe_reg_t;

	// Configuration as the datapath sees it, image sizes already clamped.
	typedef struct packed {
		logic [9:0] dest_x;
		logic [9:0] dest_y;
		logic [9:0] last_col;
		logic [9:0] last_row;
		logic       exposure_enable;
		logic [7:0] exposure_value;
		logic [7:0] alpha_threshold;
	} akbe_cfg_t;

	// One pixel beat held between the scan stage and the shading stage.
	typedef struct packed {
		logic [31:0] source_pixel;
		logic [10:0] screen_x;
		logic [10:0] screen_y;
		logic        last_pixel;
		logic        outside_screen;
	} akbe_beat_t;

endpackage

FILE: design/akbe_pixel_if.sv
// Source pixel channel: valid/ready handshake carrying one ARGB pixel.
// Depends on nothing.
interface akbe_pixel_if;
	logic        valid;
	logic        ready;
	logic [31:0] source_pixel;

	modport source (output valid, output source_pixel, input ready);
	modport sink (input valid, input source_pixel, output ready);
endinterface

FILE: design/akbe_result_if.sv
// Result channel: valid/ready handshake carrying one screen-buffer write.
// Depends on nothing.
interface akbe_result_if;
	logic        valid;
	logic        ready;
	logic        write_enable;
	logic [19:0] pixel_address;
	logic [23:0] shaded_rgb;
	logic        last_pixel;
	logic        outside_screen;

	modport source (output valid, output write_enable, output pixel_address,
		output shaded_rgb, output last_pixel, output outside_screen, input ready);
	modport sink (input valid, input write_enable, input pixel_address,
		input shaded_rgb, input last_pixel, input outside_screen, output ready);
endinterface

FILE: design/alpha_keyed_blit_with_exposure_unit.sv
// Top level of the alpha-keyed sprite blit with exposure scaling.
// Depends on akbe_pkg, akbe_pixel_if, akbe_result_if, akbe_cfg_regs,
// akbe_scan and akbe_shade.
//
// Usage:
//   Source ARGB pixels arrive in row-major order on the pixels channel, one
//   beat per pixel. Each beat yields exactly one result beat on the results
//   channel: write enable, 20-bit screen-buffer address, 24-bit colour,
//   last-pixel and off-screen flags. Registers are set over the APB-style
//   port while no pixel is in flight; pready is always high.
//   An accepted beat is captured in the stage-one register, then moves to the
//   result register, from which it is offered on the results channel.
//   Throughput: one pixel per cycle while the receiver takes results, set by the two-stage pipeline; every
//   unit (counters, three 8x8 channel multipliers, the address multiply by
//   the screen width) takes one beat per cycle.
//   When the receiver stalls, the result register holds its beat and the
//   first stage fills; pixels.ready drops only once both stages are full.
//   Reset clears the counters, both valid flags and the registers to their
//   defaults (alpha threshold 255, image size 1 by 1, exposure off).
module alpha_keyed_blit_with_exposure_unit #(
	parameter int SCREEN_WIDTH  = akbe_pkg::ScreenWidthDefault,
	parameter int SCREEN_HEIGHT = akbe_pkg::ScreenHeightDefault
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [akbe_pkg::CfgAddrW-1:0] paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready,
	akbe_pixel_if.sink                    pixels,
	akbe_result_if.source                 results
);
	import akbe_pkg::*;

	akbe_cfg_t  cfg;
	akbe_beat_t beat_s1;
	logic       valid_s1;
	logic       adv_s1;

	// Configuration registers.
	akbe_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Counters and first stage.
	akbe_scan #(
		.SCREEN_WIDTH  (SCREEN_WIDTH),
		.SCREEN_HEIGHT (SCREEN_HEIGHT)
	) u_scan (
		.clk      (clk),
		.arst_n   (arst_n),
		.pixels   (pixels),
		.cfg      (cfg),
		.adv_s1   (adv_s1),
		.beat_s1  (beat_s1),
		.valid_s1 (valid_s1)
	);

	// Key, exposure, address and result register.
	akbe_shade #(
		.SCREEN_WIDTH (SCREEN_WIDTH)
	) u_shade (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.beat_s1  (beat_s1),
		.valid_s1 (valid_s1),
		.adv_s1   (adv_s1),
		.results  (results)
	);

endmodule

FILE: design/akbe_cfg_regs.sv
// APB-style configuration registers with readback and image-size clamping.
// Depends on akbe_pkg.
module akbe_cfg_regs (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [akbe_pkg::CfgAddrW-1:0]       paddr,
	input  logic [31:0]                         pwdata,
	output logic [31:0]                         prdata,
	output logic                                pready,
	output akbe_pkg::akbe_cfg_t                 cfg
);
	import akbe_pkg::*;

	logic [9:0]  dest_x_q;
	logic [9:0]  dest_y_q;
	logic [10:0] image_width_q;
	logic [10:0] image_height_q;
	logic        exposure_enable_q;
	logic [7:0]  exposure_value_q;
	logic [7:0]  alpha_threshold_q;
	logic        wr_en;
	akbe_reg_t   reg_sel;

	// A size of zero acts as one, a size above the maximum acts as the maximum.
	function automatic logic [9:0] last_index(input logic [10:0] side);
		if (side == 11'd0) begin
			return 10'd0;
		end else if (side > 11'(MaxSide)) begin
			return 10'(MaxSide - 1);
		end else begin
			return 10'(side - 11'd1);
		end
	endfunction

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite && pready;
	assign reg_sel = akbe_reg_t'(paddr[4:2]);

	// Register writes in the access phase.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dest_x_q          <= '0;
			dest_y_q          <= '0;
			image_width_q     <= 11'd1;
			image_height_q    <= 11'd1;
			exposure_enable_q <= 1'b0;
			exposure_value_q  <= '0;
			alpha_threshold_q <= 8'hFF;
		end else if (wr_en) begin
			unique case (reg_sel)
				REG_DEST_X:          dest_x_q          <= pwdata[9:0];
				REG_DEST_Y:          dest_y_q          <= pwdata[9:0];
				REG_IMAGE_WIDTH:     image_width_q     <= pwdata[10:0];
				REG_IMAGE_HEIGHT:    image_height_q    <= pwdata[10:0];
				REG_EXPOSURE_ENABLE: exposure_enable_q <= pwdata[0];
				REG_EXPOSURE_VALUE:  exposure_value_q  <= pwdata[7:0];
				REG_ALPHA_THRESHOLD: alpha_threshold_q <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	// Readback of the stored values.
	always_comb begin
		unique case (reg_sel)
			REG_DEST_X:          prdata = 32'(dest_x_q);
			REG_DEST_Y:          prdata = 32'(dest_y_q);
			REG_IMAGE_WIDTH:     prdata = 32'(image_width_q);
			REG_IMAGE_HEIGHT:    prdata = 32'(image_height_q);
			REG_EXPOSURE_ENABLE: prdata = 32'(exposure_enable_q);
			REG_EXPOSURE_VALUE:  prdata = 32'(exposure_value_q);
			REG_ALPHA_THRESHOLD: prdata = 32'(alpha_threshold_q);
			default:             prdata = '0;
		endcase
	end

	// Datapath view of the configuration.
	always_comb begin
		cfg.dest_x          = dest_x_q;
		cfg.dest_y          = dest_y_q;
		cfg.last_col        = last_index(image_width_q);
		cfg.last_row        = last_index(image_height_q);
		cfg.exposure_enable = exposure_enable_q;
		cfg.exposure_value  = exposure_value_q;
		cfg.alpha_threshold = alpha_threshold_q;
	end

	a_thresh_write: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en && reg_sel == REG_ALPHA_THRESHOLD |=> alpha_threshold_q == $past(pwdata[7:0]))
		else $error("alpha threshold write lost");

endmodule

FILE: design/akbe_scan.sv
// Scan stage: column and row counters, screen position and first pipeline
// register. Depends on akbe_pkg and akbe_pixel_if.
module akbe_scan #(
	parameter int SCREEN_WIDTH  = akbe_pkg::ScreenWidthDefault,
	parameter int SCREEN_HEIGHT = akbe_pkg::ScreenHeightDefault
) (
	input  logic                 clk,
	input  logic                 arst_n,
	akbe_pixel_if.sink           pixels,
	input  akbe_pkg::akbe_cfg_t  cfg,
	input  logic                 adv_s1,
	output akbe_pkg::akbe_beat_t beat_s1,
	output logic                 valid_s1
);
	import akbe_pkg::*;

	logic [9:0]  col_q;
	logic [9:0]  row_q;
	logic        accept;
	logic        col_end;
	logic        row_end;
	logic [10:0] screen_x;
	logic [10:0] screen_y;
	akbe_beat_t  beat;

	assign pixels.ready = !valid_s1 || adv_s1;
	assign accept       = pixels.valid && pixels.ready;

	// Position of the current pixel on the screen.
	always_comb begin
		col_end             = col_q >= cfg.last_col;
		row_end             = row_q >= cfg.last_row;
		screen_x            = 11'(cfg.dest_x) + 11'(col_q);
		screen_y            = 11'(cfg.dest_y) + 11'(row_q);
		beat.source_pixel   = pixels.source_pixel;
		beat.screen_x       = screen_x;
		beat.screen_y       = screen_y;
		beat.last_pixel     = col_end && row_end;
		beat.outside_screen = (32'(screen_x) >= 32'(SCREEN_WIDTH)) ||
			(32'(screen_y) >= 32'(SCREEN_HEIGHT));
	end

	// Counters step once per accepted beat; the image wraps at its end.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (col_end) begin
				col_q <= '0;
				row_q <= row_end ? 10'd0 : row_q + 10'd1;
			end else begin
				col_q <= col_q + 10'd1;
			end
		end
	end

	// Stage one valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pixels.ready) begin
			valid_s1 <= pixels.valid;
		end
	end

	// Stage one payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			beat_s1 <= beat;
		end
	end

	a_col_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		accept && col_end |=> col_q == 10'd0)
		else $error("column counter did not wrap");

	a_col_step: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !col_end |=> col_q == $past(col_q) + 10'd1 && row_q == $past(row_q))
		else $error("column counter did not step");

endmodule

FILE: design/akbe_shade.sv
// Shading stage: alpha key, exposure scaling, screen address and the result
// register. Depends on akbe_pkg and akbe_result_if.
module akbe_shade #(
	parameter int SCREEN_WIDTH = akbe_pkg::ScreenWidthDefault
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  akbe_pkg::akbe_cfg_t  cfg,
	input  akbe_pkg::akbe_beat_t beat_s1,
	input  logic                 valid_s1,
	output logic                 adv_s1,
	akbe_result_if.source        results
);
	import akbe_pkg::*;

	localparam logic [12:0] ScreenW = 13'(SCREEN_WIDTH);

	logic        valid_s2;
	logic        write_enable_s2;
	logic [19:0] pixel_address_s2;
	logic [23:0] shaded_rgb_s2;
	logic        last_pixel_s2;
	logic        outside_s2;
	logic [7:0]  alpha;
	logic [23:0] color;
	logic [23:0] color_out;
	logic [24:0] addr_full;

	// Exact floor(c * v / 255) for 8-bit operands, by reciprocal and shift.
	function automatic logic [7:0] scale_channel(input logic [7:0] c, input logic [7:0] v);
		logic [15:0] prod;
		logic [16:0] sum;
		prod = 16'(c) * 16'(v);
		sum  = 17'(prod) + 17'(prod[15:8]) + 17'd1;
		return sum[15:8];
	endfunction

	assign adv_s1 = !valid_s2 || results.ready;

	// Colour, key and address for the beat in stage one.
	always_comb begin
		alpha = beat_s1.source_pixel[31:24];
		color = beat_s1.source_pixel[23:0];
		if (cfg.exposure_enable) begin
			color_out = {scale_channel(color[23:16], cfg.exposure_value),
				scale_channel(color[15:8], cfg.exposure_value),
				scale_channel(color[7:0], cfg.exposure_value)};
		end else begin
			color_out = color;
		end
		addr_full = 25'(beat_s1.screen_y) * 25'(ScreenW) + 25'(beat_s1.screen_x);
	end

	// Result valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s1) begin
			valid_s2 <= valid_s1;
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (adv_s1 && valid_s1) begin
			write_enable_s2  <= (alpha >= cfg.alpha_threshold) && !beat_s1.outside_screen;
			pixel_address_s2 <= beat_s1.outside_screen ? 20'd0 : addr_full[19:0];
			shaded_rgb_s2    <= color_out;
			last_pixel_s2    <= beat_s1.last_pixel;
			outside_s2       <= beat_s1.outside_screen;
		end
	end

	assign results.valid          = valid_s2;
	assign results.write_enable   = write_enable_s2;
	assign results.pixel_address  = pixel_address_s2;
	assign results.shaded_rgb     = shaded_rgb_s2;
	assign results.last_pixel     = last_pixel_s2;
	assign results.outside_screen = outside_s2;

	a_off_screen: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && outside_s2 |-> !write_enable_s2 && pixel_address_s2 == 20'd0)
		else $error("off-screen pixel would be written");

	a_stage_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv_s1 |=> valid_s1 && valid_s2)
		else $error("beat dropped while the result stalled");

endmodule

FILE: sim/akbe_blit_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the alpha-keyed blit: shadows the register file, predicts each result beat.
// Depends on akbe_pkg, akbe_pixel_if and akbe_result_if.
module akbe_blit_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic                          pready,
	input  logic [akbe_pkg::CfgAddrW-1:0] paddr,
	input  logic [31:0]                   pwdata,
	akbe_pixel_if                         pixels,
	akbe_result_if                        results,
	output int                            fail_count,
	output int                            pending_beats
);
	import akbe_pkg::*;

	// One screen-buffer write as the block should present it.
	typedef struct packed {
		logic        write_enable;
		logic [19:0] pixel_address;
		logic [23:0] shaded_rgb;
		logic        last_pixel;
		logic        outside_screen;
	} screen_write_t;

	akbe_cfg_t     shadow_cfg;
	logic [9:0]    column_count;
	logic [9:0]    row_count;
	screen_write_t expected_writes[$];
	screen_write_t want;
	screen_write_t got;
	int            mismatches;

	// An image side of zero behaves as one, anything above the maximum as the maximum.
	function automatic logic [9:0] last_index(input logic [10:0] side);
		if (side == 11'd0)
			return 10'd0;
		if (int'(side) > MaxSide)
			return 10'(MaxSide - 1);
		return 10'(side - 11'd1);
	endfunction

	function automatic logic [7:0] scale_channel(input logic [7:0] c, input logic [7:0] k);
		return 8'((16'(c) * 16'(k)) / 16'd255);
	endfunction

	// Works out the write that a source pixel causes at the current scan position.
	function automatic screen_write_t predict_write(input logic [31:0] px);
		screen_write_t w;
		logic [10:0]   sx;
		logic [10:0]   sy;
		sx = 11'(shadow_cfg.dest_x) + 11'(column_count);
		sy = 11'(shadow_cfg.dest_y) + 11'(row_count);
		w.outside_screen = (int'(sx) >= ScreenWidthDefault) ||
			(int'(sy) >= ScreenHeightDefault);
		w.write_enable = (px[31:24] >= shadow_cfg.alpha_threshold) && !w.outside_screen;
		w.pixel_address = w.outside_screen ? 20'd0 :
			20'(int'(sy) * ScreenWidthDefault + int'(sx));
		if (shadow_cfg.exposure_enable)
			w.shaded_rgb = {scale_channel(px[23:16], shadow_cfg.exposure_value),
				scale_channel(px[15:8], shadow_cfg.exposure_value),
				scale_channel(px[7:0], shadow_cfg.exposure_value)};
		else
			w.shaded_rgb = px[23:0];
		w.last_pixel = (column_count >= shadow_cfg.last_col) &&
			(row_count >= shadow_cfg.last_row);
		return w;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shadow_cfg <= '{dest_x: 10'd0, dest_y: 10'd0, last_col: 10'd0, last_row: 10'd0,
				exposure_enable: 1'b0, exposure_value: 8'd0, alpha_threshold: 8'hFF};
			column_count <= 10'd0;
			row_count <= 10'd0;
			expected_writes.delete();
			mismatches = 0;
			fail_count <= 0;
			pending_beats <= 0;
		end else begin
			// Register writes complete on the access cycle.
			if (psel && penable && pwrite && pready) begin
				case (akbe_reg_t'(paddr[CfgAddrW-1:2]))
					REG_DEST_X:          shadow_cfg.dest_x <= pwdata[9:0];
					REG_DEST_Y:          shadow_cfg.dest_y <= pwdata[9:0];
					REG_IMAGE_WIDTH:     shadow_cfg.last_col <= last_index(pwdata[10:0]);
					REG_IMAGE_HEIGHT:    shadow_cfg.last_row <= last_index(pwdata[10:0]);
					REG_EXPOSURE_ENABLE: shadow_cfg.exposure_enable <= pwdata[0];
					REG_EXPOSURE_VALUE:  shadow_cfg.exposure_value <= pwdata[7:0];
					REG_ALPHA_THRESHOLD: shadow_cfg.alpha_threshold <= pwdata[7:0];
					default: ;
				endcase
			end

			// Result beats are matched before this edge's pixel is queued, since a pixel
			// never yields its result at the edge on which it is accepted.
			if (results.valid && results.ready) begin
				got = '{results.write_enable, results.pixel_address, results.shaded_rgb,
					results.last_pixel, results.outside_screen};
				if (expected_writes.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: result beat with nothing outstanding: ", $realtime,
							"we=%0b addr=%h colour=%h last=%0b off=%0b",
							got.write_enable, got.pixel_address, got.shaded_rgb,
							got.last_pixel, got.outside_screen);
				end else begin
					want = expected_writes.pop_front();
					if (got !== want) begin
						mismatches++;
						if (mismatches <= 10)
							$display("%0t: result mismatch: ", $realtime,
								"expected we=%0b addr=%h colour=%h last=%0b off=%0b, ",
								want.write_enable, want.pixel_address,
								want.shaded_rgb, want.last_pixel, want.outside_screen,
								"got we=%0b addr=%h colour=%h last=%0b off=%0b",
								got.write_enable, got.pixel_address, got.shaded_rgb,
								got.last_pixel, got.outside_screen);
					end
				end
			end

			// Each accepted pixel predicts one write and advances the scan position.
			if (pixels.valid && pixels.ready) begin
				expected_writes.push_back(predict_write(pixels.source_pixel));
				if (column_count >= shadow_cfg.last_col) begin
					column_count <= 10'd0;
					row_count <= (row_count >= shadow_cfg.last_row) ? 10'd0 : row_count + 10'd1;
				end else begin
					column_count <= column_count + 10'd1;
				end
			end

			fail_count <= mismatches;
			pending_beats <= expected_writes.size();
		end
	end

endmodule

FILE: sim/alpha_keyed_blit_with_exposure_unit_tb.sv
`timescale 1ns / 100ps
// Testbench top for the alpha-keyed blit: clock, reset, register set-up, pixel stimulus, verdict.
// Depends on akbe_pkg, both channel interfaces, the block itself and akbe_blit_checker.
module alpha_keyed_blit_with_exposure_unit_tb;
	import akbe_pkg::*;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                psel = 1'b0;
	logic                penable = 1'b0;
	logic                pwrite = 1'b0;
	logic [CfgAddrW-1:0] paddr = '0;
	logic [31:0]         pwdata = '0;
	logic [31:0]         prdata;
	logic                pready;
	int                  fail_count;
	int                  pending_beats;

	logic [7:0]  alpha_key;
	logic [31:0] pixel_plan[$];
	logic [31:0] reg_values[7];
	int          pixels_sent;
	int          stall_mode;
	int          stall_left;

	akbe_pixel_if  pix_ch();
	akbe_result_if res_ch();

	always #2 clk = ~clk;

	alpha_keyed_blit_with_exposure_unit uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.pixels  (pix_ch),
		.results (res_ch)
	);

	akbe_blit_checker scoreboard (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.pready        (pready),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.pixels        (pix_ch),
		.results       (res_ch),
		.fail_count    (fail_count),
		.pending_beats (pending_beats)
	);

	// The receiver switches between always ready, light stalls and heavy stalls.
	always @(posedge clk) begin
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
			stall_mode <= 0;
			stall_left <= 0;
		end else begin
			if (stall_left == 0) begin
				stall_mode <= $urandom_range(0, 2);
				stall_left <= $urandom_range(20, 200);
			end else begin
				stall_left <= stall_left - 1;
			end
			case (stall_mode)
				0:       res_ch.ready <= 1'b1;
				1:       res_ch.ready <= ($urandom_range(0, 3) != 0);
				default: res_ch.ready <= ($urandom_range(0, 7) == 0);
			endcase
		end
	end

	// Writes all seven registers in index order, then releases the bus.
	task automatic program_regs();
		for (int i = REG_DEST_X; i <= REG_ALPHA_THRESHOLD; i++) begin
			psel <= 1'b1;
			penable <= 1'b0;
			pwrite <= 1'b1;
			paddr <= CfgAddrW'(4 * i);
			pwdata <= reg_values[i];
			@(posedge clk);
			penable <= 1'b1;
			@(posedge clk);
		end
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		alpha_key = reg_values[REG_ALPHA_THRESHOLD][7:0];
	endtask

	// Waits until every predicted beat has been seen, then lets the pipeline settle.
	task automatic drain();
		@(posedge clk);
		while (pending_beats != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Streams the planned pixels in bursts, with short gaps or a full drain between them.
	task automatic send_plan();
		int burst_left;
		burst_left = $urandom_range(1, ($urandom_range(0, 3) == 0) ? 200 : 12);
		while (pixel_plan.size() != 0) begin
			pix_ch.valid <= 1'b1;
			pix_ch.source_pixel <= pixel_plan.pop_front();
			@(posedge clk);
			while (!pix_ch.ready)
				@(posedge clk);
			pixels_sent++;
			burst_left--;
			if (burst_left == 0 && pixel_plan.size() != 0) begin
				pix_ch.valid <= 1'b0;
				if ($urandom_range(0, 15) == 0) begin
					@(posedge clk);
					while (pending_beats != 0)
						@(posedge clk);
				end else begin
					repeat ($urandom_range(1, 8)) @(posedge clk);
				end
				burst_left = $urandom_range(1, ($urandom_range(0, 3) == 0) ? 200 : 12);
			end
		end
		pix_ch.valid <= 1'b0;
	endtask

	// Image sides lean towards small images so that whole frames wrap often.
	function automatic logic [31:0] pick_side();
		case ($urandom_range(0, 11))
			0:       return 32'd0;
			1:       return 32'd1024;
			2:       return $urandom_range(1025, 2047);
			3:       return $urandom_range(2, 64);
			default: return $urandom_range(1, 12);
		endcase
	endfunction

	function automatic logic [31:0] pick_byte_extreme();
		case ($urandom_range(0, 6))
			0:       return 32'd0;
			1:       return 32'd1;
			2:       return 32'd254;
			3:       return 32'd255;
			default: return $urandom_range(0, 255);
		endcase
	endfunction

	// Alpha is steered around the key so that both sides of the compare are hit.
	function automatic logic [31:0] pick_pixel();
		logic [31:0] px;
		px = $urandom();
		case ($urandom_range(0, 5))
			0:       px[31:24] = alpha_key;
			1:       px[31:24] = alpha_key - 8'd1;
			2:       px[31:24] = alpha_key + 8'd1;
			default: ;
		endcase
		return px;
	endfunction

	initial begin
		pix_ch.valid = 1'b0;
		pix_ch.source_pixel = '0;
		pixels_sent = 0;
		alpha_key = 8'hFF;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: a one-pixel image at the origin, key at full alpha.
		pixel_plan = '{32'h0000_0000, 32'hFFFF_FFFF, 32'hFE80_8080, 32'hFF00_0000};
		send_plan();
		drain();

		// A window across the bottom-right corner, exposure at unity, nothing keyed out.
		reg_values[REG_DEST_X] = 32'd1021;
		reg_values[REG_DEST_Y] = 32'd766;
		reg_values[REG_IMAGE_WIDTH] = 32'd5;
		reg_values[REG_IMAGE_HEIGHT] = 32'd3;
		reg_values[REG_EXPOSURE_ENABLE] = 32'd1;
		reg_values[REG_EXPOSURE_VALUE] = 32'd255;
		reg_values[REG_ALPHA_THRESHOLD] = 32'd0;
		program_regs();
		for (int i = 0; i < 15; i++)
			pixel_plan.push_back((i % 3 == 0) ? 32'h00FF_FFFF :
				(i % 3 == 1) ? 32'hFF00_0000 : 32'h7F5A_A5C3);
		send_plan();
		drain();

		// Exposure at zero, one and about half scale, with the image at the screen origin.
		reg_values[REG_DEST_X] = 32'd0;
		reg_values[REG_DEST_Y] = 32'd0;
		reg_values[REG_EXPOSURE_VALUE] = 32'd0;
		program_regs();
		pixel_plan = '{32'hFFFF_FFFF, 32'h8012_3456};
		send_plan();
		drain();
		reg_values[REG_EXPOSURE_VALUE] = 32'd1;
		program_regs();
		pixel_plan = '{32'hFFFF_FFFF};
		send_plan();
		drain();
		reg_values[REG_EXPOSURE_VALUE] = 32'd128;
		program_regs();
		pixel_plan = '{32'hFFFF_FFFF};
		send_plan();
		drain();

		// Random phases: fresh settings each time; the scan position carries over.
		while (pixels_sent < 1000) begin
			case ($urandom_range(0, 4))
				0:       reg_values[REG_DEST_X] = 32'd0;
				1:       reg_values[REG_DEST_X] = 32'd1023;
				2:       reg_values[REG_DEST_X] = 32'd1024 - $urandom_range(1, 20);
				default: reg_values[REG_DEST_X] = $urandom_range(0, 1023);
			endcase
			case ($urandom_range(0, 5))
				0:       reg_values[REG_DEST_Y] = 32'd0;
				1:       reg_values[REG_DEST_Y] = 32'd767;
				2:       reg_values[REG_DEST_Y] = 32'd768 - $urandom_range(1, 8);
				3:       reg_values[REG_DEST_Y] = $urandom_range(768, 1023);
				default: reg_values[REG_DEST_Y] = $urandom_range(0, 1023);
			endcase
			reg_values[REG_IMAGE_WIDTH] = pick_side();
			reg_values[REG_IMAGE_HEIGHT] = pick_side();
			reg_values[REG_EXPOSURE_ENABLE] = $urandom_range(0, 1);
			reg_values[REG_EXPOSURE_VALUE] = pick_byte_extreme();
			reg_values[REG_ALPHA_THRESHOLD] = pick_byte_extreme();
			program_regs();
			repeat ($urandom_range(40, 100))
				pixel_plan.push_back(pick_pixel());
			send_plan();
			drain();
		end

		repeat (8) @(posedge clk);
		if (fail_count == 0 && pending_beats == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	// Watchdog far beyond the slowest correct run.
	initial begin
		#2_000_000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule
